// ===== rtl/core/dtr_pkg.sv =====
// Package for the divider timer with reload: item types, access codes and
// the timer tap selection. No dependencies.
`default_nettype none

package dtr_pkg;

	// Access kinds carried in the mode field.
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;

	// Register addresses carried in the reg_select field.
	localparam logic [1:0] REG_DIV  = 2'd0;
	localparam logic [1:0] REG_CNT  = 2'd1;
	localparam logic [1:0] REG_MOD  = 2'd2;
	localparam logic [1:0] REG_CTRL = 2'd3;

	localparam logic [15:0] DIV_STEP       = 16'd4;
	localparam logic [7:0]  CTRL_READ_ONES = 8'hf8;
	localparam int          CTRL_ON_BIT    = 2;

	typedef struct packed {
		logic [1:0] mode;
		logic [1:0] reg_select;
		logic [7:0] write_data;
	} dtr_in_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       timer_irq;
	} dtr_out_t;

	// Divider bit that clocks the counter for a given rate code.
	function automatic logic tap_bit(input logic [1:0] rate, input logic [15:0] div);
		logic b;
		case (rate)
			2'd0:    b = div[9];
			2'd1:    b = div[3];
			2'd2:    b = div[5];
			default: b = div[7];
		endcase
		return b;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/dtr_core.sv =====
// Timer state and the update applied to one accepted item.
// Depends on dtr_pkg.
`default_nettype none

module dtr_core (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire dtr_pkg::dtr_in_t item,
	output dtr_pkg::dtr_out_t     res
);
	import dtr_pkg::*;

	logic [15:0] div_q, div_d;
	logic [7:0]  cnt_q, cnt_d;
	logic [7:0]  mod_q, mod_d;
	logic        on_q, on_d;
	logic [1:0]  rate_q, rate_d;
	logic        pend_q, pend_d;
	logic        done_q, done_d;

	logic        div_upd;
	logic [15:0] div_next;
	logic        was, now, glitch, new_on;
	logic [1:0]  new_rate;

	always_comb begin
		div_d    = div_q;
		cnt_d    = cnt_q;
		mod_d    = mod_q;
		on_d     = on_q;
		rate_d   = rate_q;
		pend_d   = pend_q;
		done_d   = done_q;
		res      = '0;
		glitch   = 1'b0;
		new_on   = item.write_data[CTRL_ON_BIT];
		new_rate = item.write_data[1:0];

		div_upd  = (item.mode == MODE_TICK) ||
			(item.mode == MODE_WRITE && item.reg_select == REG_DIV);
		div_next = (item.mode == MODE_TICK) ? div_q + DIV_STEP : '0;
		was      = tap_bit(rate_q, div_q);
		now      = tap_bit(rate_q, div_next);

		if (div_upd) begin
			div_d  = div_next;
			done_d = 1'b0;
			// A pending reload lands before this update's own increment.
			if (pend_q) begin
				pend_d        = 1'b0;
				cnt_d         = mod_q;
				res.timer_irq = 1'b1;
				done_d        = 1'b1;
			end
			if (on_q && was && !now) begin
				cnt_d = cnt_d + 8'd1;
				if (cnt_d == '0) begin
					pend_d = 1'b1;
				end
			end
		end else if (item.mode == MODE_READ) begin
			unique case (item.reg_select)
				REG_DIV: res.read_data = div_q[15:8];
				REG_CNT: res.read_data = pend_q ? '0 : cnt_q;
				REG_MOD: res.read_data = mod_q;
				default: res.read_data = CTRL_READ_ONES | {5'd0, on_q, rate_q};
			endcase
		end else if (item.mode == MODE_WRITE) begin
			unique case (item.reg_select)
				REG_CNT: begin
					if (!done_q) begin
						cnt_d  = item.write_data;
						pend_d = 1'b0;
					end
				end
				REG_MOD: begin
					mod_d = item.write_data;
					if (done_q) begin
						cnt_d = item.write_data;
					end
				end
				default: begin
					on_d   = new_on;
					rate_d = new_rate;
					// Switching the enable or the tap can fake a falling edge.
					if (on_q) begin
						glitch = !new_on && tap_bit(new_rate, div_q);
					end else if (new_on) begin
						glitch = tap_bit(rate_q, div_q) && !tap_bit(new_rate, div_q);
					end else begin
						glitch = tap_bit(rate_q, div_q);
					end
					if (glitch) begin
						cnt_d = cnt_q + 8'd1;
						if (cnt_d == '0) begin
							pend_d = 1'b1;
						end
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_q  <= '0;
			cnt_q  <= '0;
			mod_q  <= '0;
			on_q   <= 1'b0;
			rate_q <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else if (accept) begin
			div_q  <= div_d;
			cnt_q  <= cnt_d;
			mod_q  <= mod_d;
			on_q   <= on_d;
			rate_q <= rate_d;
			pend_q <= pend_d;
			done_q <= done_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/divider_timer_with_reload.sv =====
// Divider timer with delayed counter reload. Every item (tick or register access)
// updates the timer state in the cycle it is accepted; its result is registered for output.
// It takes one item per cycle while the skid register is empty, which drives item_ready.
// A two-entry output buffer (result register plus skid register) keeps input flowing
// while one result waits. Reset clears all timer state and empties the output buffer.
`default_nettype none

module divider_timer_with_reload (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire dtr_pkg::dtr_in_t item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output dtr_pkg::dtr_out_t     result
);
	import dtr_pkg::*;

	dtr_out_t core_res;
	dtr_out_t result_q, skid_q;
	logic     result_valid_q, skid_valid_q;
	logic     accept, take;

	assign item_ready   = !skid_valid_q;
	assign accept       = item_valid && item_ready;
	assign take         = result_valid_q && result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	dtr_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.res    (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
			skid_valid_q   <= 1'b0;
		end else begin
			result_valid_q <= accept || skid_valid_q || (result_valid_q && !result_ready);
			if (skid_valid_q) begin
				if (take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (accept && result_valid_q && !result_ready) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (take) begin
				result_q <= skid_q;
			end
		end else if (accept) begin
			if (!result_valid_q || result_ready) begin
				result_q <= core_res;
			end else begin
				skid_q <= core_res;
			end
		end
	end

`ifndef ASSERT_OFF
	a_skid_implies_result: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> result_valid_q)
		else $error("skid entry held while result register is empty");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> result_valid_q)
		else $error("accepted item left no result");

	a_irq_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.timer_irq) |-> (result.read_data == '0))
		else $error("interrupt result carries read data");
`endif

endmodule

`default_nettype wire
